// ----- rtl/smam_pkg.sv -----
package smam_pkg;

	// Request codes on the req_type field.
	localparam logic [1:0] REQ_WRITE_A = 2'd0;
	localparam logic [1:0] REQ_WRITE_B = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_ROWS = 2'd1;
	localparam logic [1:0] CFG_COLS = 2'd2;

	// Field widths fixed by the interface.
	localparam int IDX_BITS  = 3;
	localparam int VAL_BITS  = 32;
	localparam int DIMR_BITS = 4;

	// Work kinds that pass from the front to the back.
	typedef enum logic [1:0] {
		KIND_WRITE_A,
		KIND_WRITE_B,
		KIND_COMPUTE
	} kind_t;

	// One queued word of work.
	typedef struct packed {
		kind_t                 kind;
		logic [IDX_BITS-1:0]   row;
		logic [IDX_BITS-1:0]   col;
		logic [VAL_BITS-1:0]   value;
	} queue_entry_t;

	// Configuration register set.
	typedef struct packed {
		logic                  mode;
		logic [DIMR_BITS-1:0]  rows;
		logic [DIMR_BITS-1:0]  cols;
	} cfg_t;

	// Sequencer states of the back part.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_ISSUE
	} back_state_t;

endpackage

// ----- rtl/smam_ram.sv -----
module smam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/smam_front.sv -----
module smam_front import smam_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [IDX_BITS-1:0]  row_index,
	input  logic [IDX_BITS-1:0]  col_index,
	input  logic [VAL_BITS-1:0]  elem_value,
	output logic                 q_valid,
	output queue_entry_t         q_head,
	input  logic                 q_pop
);

	queue_entry_t ent_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         keep;
	logic         push;
	logic         in_range;
	kind_t        kind;

	// Writes outside the stored matrix and unused request codes are dropped here.
	assign in_range = ({5'd0, row_index} < 8'(MAX_DIM)) && ({5'd0, col_index} < 8'(MAX_DIM));

	always_comb begin
		kind = KIND_COMPUTE;
		keep = 1'b0;
		case (req_type)
			REQ_WRITE_A: begin
				kind = KIND_WRITE_A;
				keep = in_range;
			end
			REQ_WRITE_B: begin
				kind = KIND_WRITE_B;
				keep = in_range;
			end
			REQ_COMPUTE: begin
				kind = KIND_COMPUTE;
				keep = 1'b1;
			end
			default: begin
				kind = KIND_COMPUTE;
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = (count_q != 2'd0);
	assign q_head   = ent_q[rd_ptr_q];

	// Two-word queue between the front and the back.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{kind: kind, row: row_index, col: col_index, value: elem_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/smam_back.sv -----
module smam_back import smam_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        q_valid,
	input  queue_entry_t                q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [IDX_BITS-1:0]         out_row,
	output logic [IDX_BITS-1:0]         out_col,
	output logic signed [VAL_BITS-1:0]  out_value,
	output logic                        last
);

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int AW    = 2 * IDX_W;
	localparam int DEPTH = 1 << AW;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [DIM_W-1:0]   nr;
	logic [DIM_W-1:0]   nc;
	logic [DIM_W-1:0]   kmax;
	logic [DIM_W-1:0]   jmax;
	logic [DIM_W-1:0]   i_q;
	logic [DIM_W-1:0]   j_q;
	logic [DIM_W-1:0]   k_q;
	logic               k_last;
	logic               j_last;
	logic               i_last;
	logic               issue;
	logic               start;
	logic               inflight;
	logic               a_we;
	logic               b_we;
	logic [7:0]         wrow;
	logic [7:0]         wcol;
	logic [AW-1:0]      waddr;
	logic [DIM_W-1:0]   a_col;
	logic [DIM_W-1:0]   b_row;
	logic [AW-1:0]      a_raddr;
	logic [AW-1:0]      b_raddr;
	logic [VAL_BITS-1:0] a_rdata;
	logic [VAL_BITS-1:0] b_rdata;

	logic                v_s1;
	logic                first_s1;
	logic                lastk_s1;
	logic                last_s1;
	logic                mul_s1;
	logic [IDX_BITS-1:0] row_s1;
	logic [IDX_BITS-1:0] col_s1;
	logic                v_s2;
	logic                first_s2;
	logic                lastk_s2;
	logic                last_s2;
	logic [IDX_BITS-1:0] row_s2;
	logic [IDX_BITS-1:0] col_s2;
	logic [VAL_BITS-1:0] op_s2;
	logic [VAL_BITS-1:0] acc_q;
	logic [VAL_BITS-1:0] sum;
	logic                out_valid_q;

	// Saturate the dimension registers to the supported range.
	always_comb begin
		if (cfg.rows == '0) begin
			nr = DIM_W'(1);
		end else if ({1'b0, cfg.rows} > 5'(MAX_DIM)) begin
			nr = DIM_W'(MAX_DIM);
		end else begin
			nr = DIM_W'(cfg.rows);
		end
		if (cfg.cols == '0) begin
			nc = DIM_W'(1);
		end else if ({1'b0, cfg.cols} > 5'(MAX_DIM)) begin
			nc = DIM_W'(MAX_DIM);
		end else begin
			nc = DIM_W'(cfg.cols);
		end
	end

	// Multiply runs the inner loop over cols; add takes one term per result.
	assign kmax   = cfg.mode ? nc : DIM_W'(1);
	assign jmax   = cfg.mode ? nr : nc;
	assign k_last = (k_q == kmax - DIM_W'(1));
	assign j_last = (j_q == jmax - DIM_W'(1));
	assign i_last = (i_q == nr - DIM_W'(1));

	assign inflight = v_s1 || v_s2;

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_head.kind == KIND_COMPUTE) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!inflight && !out_valid_q) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (k_last) begin
					state_d = (i_last && j_last) ? ST_IDLE : ST_WAIT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		q_pop = 1'b0;
		a_we  = 1'b0;
		b_we  = 1'b0;
		issue = 1'b0;
		start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
				a_we  = q_valid && q_head.kind == KIND_WRITE_A;
				b_we  = q_valid && q_head.kind == KIND_WRITE_B;
				start = q_valid && q_head.kind == KIND_COMPUTE;
			end
			ST_ISSUE: begin
				issue = 1'b1;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Loop counters over result row, result column and inner term.
	always_ff @(posedge clk) begin
		if (start) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (issue) begin
			if (!k_last) begin
				k_q <= k_q + DIM_W'(1);
			end else begin
				k_q <= '0;
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + DIM_W'(1);
				end else begin
					j_q <= j_q + DIM_W'(1);
				end
			end
		end
	end

	// Element addresses: row in the upper half, column in the lower half.
	assign wrow    = {5'd0, q_head.row};
	assign wcol    = {5'd0, q_head.col};
	assign waddr   = {wrow[IDX_W-1:0], wcol[IDX_W-1:0]};
	assign a_col   = cfg.mode ? k_q : j_q;
	assign b_row   = cfg.mode ? k_q : i_q;
	assign a_raddr = {i_q[IDX_W-1:0], a_col[IDX_W-1:0]};
	assign b_raddr = {b_row[IDX_W-1:0], j_q[IDX_W-1:0]};

	smam_ram #(
		.WIDTH (VAL_BITS),
		.DEPTH (DEPTH)
	) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (q_head.value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	smam_ram #(
		.WIDTH (VAL_BITS),
		.DEPTH (DEPTH)
	) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (q_head.value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// Stage valids and the output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2 && lastk_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1 tags travel alongside the memory read.
	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		lastk_s1 <= k_last;
		last_s1  <= i_last && j_last;
		mul_s1   <= cfg.mode;
		row_s1   <= IDX_BITS'(i_q);
		col_s1   <= IDX_BITS'(j_q);
	end

	// Stage 2 forms the product or the sum, wrapped to 32 bits.
	always_ff @(posedge clk) begin
		op_s2    <= mul_s1 ? (a_rdata * b_rdata) : (a_rdata + b_rdata);
		first_s2 <= first_s1;
		lastk_s2 <= lastk_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
	end

	// Accumulate and load the finished element into the output register.
	assign sum = first_s2 ? op_s2 : (acc_q + op_s2);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= sum;
		end
		if (v_s2 && lastk_s2) begin
			out_row   <= row_s2;
			out_col   <= col_s2;
			out_value <= sum;
			last      <= last_s2;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/small_matrix_add_multiply_top.sv -----
// Element writes: one word per cycle while in_stall is low; each word is queued, then stored when the back is idle.
// Compute: a multiply result element sums cols terms and an add result element takes one term,
// through the single shared multiply-accumulate and the one read port of each matrix store.
// Asynchronous active-low reset clears the queue, sequencer and valids; mode resets to
// multiply, rows and cols to 1. The matrix stores are not cleared.
module small_matrix_add_multiply_top import smam_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [IDX_BITS-1:0]         row_index,
	input  logic [IDX_BITS-1:0]         col_index,
	input  logic signed [VAL_BITS-1:0]  elem_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [IDX_BITS-1:0]         out_row,
	output logic [IDX_BITS-1:0]         out_col,
	output logic signed [VAL_BITS-1:0]  out_value,
	output logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [DIMR_BITS-1:0]        cfg_data
);

	cfg_t         cfg_q;
	logic         q_valid;
	logic         q_pop;
	queue_entry_t q_head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: 1'b1, rows: DIMR_BITS'(1), cols: DIMR_BITS'(1)};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE: cfg_q.mode <= cfg_data[0];
				CFG_ROWS: cfg_q.rows <= cfg_data;
				CFG_COLS: cfg_q.cols <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	smam_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.row_index  (row_index),
		.col_index  (col_index),
		.elem_value (elem_value),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	smam_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.last      (last)
	);

endmodule

// ----- test/small_matrix_add_multiply_top_tb.sv -----
module small_matrix_add_multiply_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smam_pkg::*;

	localparam int DIM            = 8;
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES         = 10;

	// Codes that the package leaves unnamed.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] CFG_SPARE  = 2'd3;
	localparam logic       MODE_ADD   = 1'b0;
	localparam logic       MODE_MUL   = 1'b1;

	// One result element as it leaves the block.
	typedef struct packed {
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
		logic [VAL_BITS-1:0] value;
		logic                last;
	} elem_t;

	// One row of the directed stimulus: a request word or a register write.
	typedef struct {
		bit                  is_cfg;
		logic [1:0]          code;
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
		logic [VAL_BITS-1:0] value;
		bit                  typed;
		logic [VAL_BITS-1:0] want;
	} step_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       in_valid   = 1'b0;
	logic                       in_stall;
	logic [1:0]                 req_type   = REQ_WRITE_A;
	logic [IDX_BITS-1:0]        row_index  = '0;
	logic [IDX_BITS-1:0]        col_index  = '0;
	logic signed [VAL_BITS-1:0] elem_value = '0;
	logic                       out_valid;
	logic                       out_stall  = 1'b0;
	logic [IDX_BITS-1:0]        out_row;
	logic [IDX_BITS-1:0]        out_col;
	logic signed [VAL_BITS-1:0] out_value;
	logic                       last;
	logic                       cfg_valid  = 1'b0;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index  = CFG_MODE;
	logic [DIMR_BITS-1:0]       cfg_data   = '0;

	// Shadow of the block: both matrix stores and the register set.
	logic [VAL_BITS-1:0]  a_mem [DIM*DIM];
	logic [VAL_BITS-1:0]  b_mem [DIM*DIM];
	logic                 cfg_mode = MODE_MUL;
	logic [DIMR_BITS-1:0] cfg_rows = 1;
	logic [DIMR_BITS-1:0] cfg_cols = 1;

	// Cells that have been written, so that no compute reads an unwritten one.
	bit a_set [DIM*DIM];
	bit b_set [DIM*DIM];

	elem_t pending_elems [$];
	step_t directed_steps [$];

	int send_gap_pct = 0;
	int stall_pct    = 0;
	int hold_left    = 0;
	int fail_cnt     = 0;
	int words_sent   = 0;
	int elems_seen   = 0;
	int quiet_cycles = 0;

	// Settings walked by the random part.
	int ph_mode  [PHASES] = '{0, 1, 1, 0, 1, 0, 1, 0, 1, 0};
	int ph_rows  [PHASES] = '{2, 3, 0, 8, 4, 9, 8, 8, 2, 1};
	int ph_cols  [PHASES] = '{3, 2, 15, 1, 4, 0, 8, 8, 5, 8};
	int ph_gap   [PHASES] = '{0, 59, 0, 21, 0, 59, 0, 21, 0, 59};
	int ph_stall [PHASES] = '{0, 0, 59, 21, 0, 0, 59, 21, 0, 0};
	int ph_quota [PHASES] = '{8, 8, 8, 8, 12, 6, 4, 4, 8, 6};

	small_matrix_add_multiply_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.row_index  (row_index),
		.col_index  (col_index),
		.elem_value (elem_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_value  (out_value),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Saturate a dimension register to the range the block uses.
	function automatic int dim_of(logic [DIMR_BITS-1:0] d);
		if (d == 0) return 1;
		if (d > DIM) return DIM;
		return int'(d);
	endfunction

	// Element values lean toward the extremes of the signed range.
	function automatic logic [VAL_BITS-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			4: return VAL_BITS'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [VAL_BITS-1:0] got,
			logic [VAL_BITS-1:0] want);
		$display("mismatch at %0t ns: %s, got %0h, expected %0h", $time, what, got, want);
		fail_cnt++;
	endtask

	// Apply one accepted word: store a write, or queue the whole result matrix.
	task automatic apply_request(logic [1:0] req, logic [IDX_BITS-1:0] row,
			logic [IDX_BITS-1:0] col, logic [VAL_BITS-1:0] value);
		int nr;
		int nc;
		int span;
		logic [VAL_BITS-1:0] acc;
		elem_t e;
		nr = dim_of(cfg_rows);
		nc = dim_of(cfg_cols);
		case (req)
			REQ_WRITE_A: a_mem[{row, col}] = value;
			REQ_WRITE_B: b_mem[{row, col}] = value;
			REQ_COMPUTE: begin
				// Add gives rows x cols, multiply gives rows x rows.
				span = (cfg_mode == MODE_ADD) ? nc : nr;
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < span; j++) begin
						if (cfg_mode == MODE_ADD) begin
							acc = a_mem[i*DIM+j] + b_mem[i*DIM+j];
						end else begin
							acc = '0;
							for (int k = 0; k < nc; k++)
								acc += a_mem[i*DIM+k] * b_mem[k*DIM+j];
						end
						e.row   = IDX_BITS'(i);
						e.col   = IDX_BITS'(j);
						e.value = acc;
						e.last  = (i == nr - 1) && (j == span - 1);
						pending_elems.push_back(e);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Offer one word, with random gaps ahead of it, and wait until it is taken.
	task automatic put_word(logic [1:0] req, logic [IDX_BITS-1:0] row,
			logic [IDX_BITS-1:0] col, logic [VAL_BITS-1:0] value, bit typed,
			logic [VAL_BITS-1:0] want);
		elem_t e;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		row_index  <= row;
		col_index  <= col;
		elem_value <= value;
		if (req == REQ_WRITE_A) a_set[{row, col}] = 1'b1;
		if (req == REQ_WRITE_B) b_set[{row, col}] = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (req != REQ_UNUSED) words_sent++;
		if (typed && req == REQ_COMPUTE) begin
			e.row   = '0;
			e.col   = '0;
			e.value = want;
			e.last  = 1'b1;
			pending_elems.push_back(e);
		end else begin
			apply_request(req, row, col, value);
		end
	endtask

	// Register write; the shadow follows at acceptance.
	task automatic write_reg(logic [1:0] idx, logic [DIMR_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MODE: cfg_mode = data[0];
			CFG_ROWS: cfg_rows = data;
			CFG_COLS: cfg_cols = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Hold the sender until every pending element is back and queued writes settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_elems.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write every cell that the next compute reads and that is still unwritten.
	task automatic fill_needed();
		int nr;
		int nc;
		nr = dim_of(cfg_rows);
		nc = dim_of(cfg_cols);
		for (int i = 0; i < nr; i++)
			for (int j = 0; j < nc; j++)
				if (!a_set[i*DIM+j])
					put_word(REQ_WRITE_A, IDX_BITS'(i), IDX_BITS'(j), pick_value(), 0, '0);
		for (int i = 0; i < ((cfg_mode == MODE_ADD) ? nr : nc); i++)
			for (int j = 0; j < ((cfg_mode == MODE_ADD) ? nc : nr); j++)
				if (!b_set[i*DIM+j])
					put_word(REQ_WRITE_B, IDX_BITS'(i), IDX_BITS'(j), pick_value(), 0, '0);
	endtask

	task automatic add_step(bit is_cfg, logic [1:0] code, logic [IDX_BITS-1:0] row,
			logic [IDX_BITS-1:0] col, logic [VAL_BITS-1:0] value, bit typed,
			logic [VAL_BITS-1:0] want);
		step_t s;
		s.is_cfg = is_cfg;
		s.code   = code;
		s.row    = row;
		s.col    = col;
		s.value  = value;
		s.typed  = typed;
		s.want   = want;
		directed_steps.push_back(s);
	endtask

	// Mostly well-formed write-then-compute sequences, with stray words mixed in.
	task automatic random_phase(int quota, bit squeeze);
		int start;
		int pick;
		start = words_sent;
		if (squeeze) begin
			// Block the output while words keep coming, so the input must stall.
			fill_needed();
			put_word(REQ_COMPUTE, '0, '0, '0, 0, '0);
			hold_left = HOLD_CYCLES;
		end
		while (words_sent - start < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				put_word(REQ_UNUSED, IDX_BITS'($urandom), IDX_BITS'($urandom), $urandom, 0, '0);
			end else if (pick < 72) begin
				put_word($urandom_range(0, 1) ? REQ_WRITE_B : REQ_WRITE_A,
					IDX_BITS'($urandom_range(0, DIM - 1)), IDX_BITS'($urandom_range(0, DIM - 1)),
					pick_value(), 0, '0);
			end else if (pick < 75) begin
				drain_results();
			end else begin
				fill_needed();
				put_word(REQ_COMPUTE, IDX_BITS'($urandom), IDX_BITS'($urandom), $urandom, 0, '0);
			end
		end
		fill_needed();
		put_word(REQ_COMPUTE, IDX_BITS'($urandom), IDX_BITS'($urandom), $urandom, 0, '0);
	endtask

	// Output side: random stalls, or one long hold-off when requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Compare each result word with the oldest pending element.
	always @(posedge clk) begin : check_results
		elem_t want;
		if (arst_n && out_valid && !out_stall) begin
			elems_seen++;
			if (pending_elems.size() == 0) begin
				report_mismatch("result word with nothing pending", out_value, '0);
			end else begin
				want = pending_elems.pop_front();
				if (out_row !== want.row)
					report_mismatch("out_row", VAL_BITS'(out_row), VAL_BITS'(want.row));
				if (out_col !== want.col)
					report_mismatch("out_col", VAL_BITS'(out_col), VAL_BITS'(want.col));
				if (out_value !== want.value)
					report_mismatch("out_value", out_value, want.value);
				if (last !== want.last)
					report_mismatch("last", VAL_BITS'(last), VAL_BITS'(want.last));
			end
		end
	end

	// End the run when no channel has moved a word for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		// Directed part: 1x1 products and sums at the extremes, an unused
		// request code, a spare register index and zero dimensions.
		add_step(0, REQ_WRITE_A, 0, 0, 32'd3, 0, '0);
		add_step(0, REQ_WRITE_B, 0, 0, 32'd5, 0, '0);
		add_step(0, REQ_COMPUTE, 0, 0, '0, 1, 32'd15);
		add_step(0, REQ_WRITE_A, 0, 0, 32'h7fff_ffff, 0, '0);
		add_step(0, REQ_WRITE_B, 0, 0, 32'd2, 0, '0);
		add_step(0, REQ_COMPUTE, 7, 7, 32'hffff_ffff, 1, 32'hffff_fffe);
		add_step(1, CFG_MODE, 0, 0, 32'(MODE_ADD), 0, '0);
		add_step(0, REQ_WRITE_B, 0, 0, 32'd1, 0, '0);
		add_step(0, REQ_COMPUTE, 0, 0, '0, 1, 32'h8000_0000);
		add_step(0, REQ_WRITE_A, 0, 0, 32'h8000_0000, 0, '0);
		add_step(0, REQ_WRITE_B, 0, 0, 32'hffff_ffff, 0, '0);
		add_step(0, REQ_COMPUTE, 0, 0, '0, 1, 32'h7fff_ffff);
		add_step(1, CFG_MODE, 0, 0, 32'(MODE_MUL), 0, '0);
		add_step(0, REQ_COMPUTE, 0, 0, '0, 1, 32'h8000_0000);
		add_step(0, REQ_UNUSED, 7, 7, 32'hffff_ffff, 0, '0);
		add_step(0, REQ_COMPUTE, 0, 0, '0, 1, 32'h8000_0000);
		add_step(1, CFG_SPARE, 0, 0, 32'd15, 0, '0);
		add_step(1, CFG_ROWS, 0, 0, 32'd0, 0, '0);
		add_step(1, CFG_COLS, 0, 0, 32'd0, 0, '0);
		add_step(0, REQ_COMPUTE, 0, 0, '0, 1, 32'h8000_0000);
		add_step(0, REQ_WRITE_A, 7, 7, 32'hffff_ffff, 0, '0);
		add_step(0, REQ_WRITE_B, 7, 7, 32'd0, 0, '0);
		add_step(0, REQ_WRITE_A, 0, 0, 32'd0, 0, '0);
		add_step(0, REQ_COMPUTE, 0, 0, '0, 1, 32'd0);
		add_step(0, REQ_COMPUTE, 5, 2, 32'h1234_5678, 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[n]) begin
			if (directed_steps[n].is_cfg) begin
				drain_results();
				write_reg(directed_steps[n].code, DIMR_BITS'(directed_steps[n].value));
			end else begin
				put_word(directed_steps[n].code, directed_steps[n].row, directed_steps[n].col,
					directed_steps[n].value, directed_steps[n].typed, directed_steps[n].want);
			end
		end

		// Random part, one setting of mode and size per phase.
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			send_gap_pct = ph_gap[p];
			stall_pct    = ph_stall[p];
			write_reg(CFG_MODE, DIMR_BITS'(ph_mode[p]));
			write_reg(CFG_ROWS, DIMR_BITS'(ph_rows[p]));
			write_reg(CFG_COLS, DIMR_BITS'(ph_cols[p]));
			if (p % 3 == 0) write_reg(CFG_SPARE, DIMR_BITS'($urandom));
			random_phase(ph_quota[p], p == 4);
		end

		drain_results();
		$display("Run covered %0d request words and %0d result elements in add and multiply,",
			words_sent, elems_seen);
		$display("with sizes from 1x1 to 8x8 including saturated ones, under gaps and stalls.");
		if (fail_cnt == 0 && pending_elems.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/smam_pkg.sv
rtl/smam_ram.sv
rtl/smam_front.sv
rtl/smam_back.sv
rtl/small_matrix_add_multiply_top.sv
test/small_matrix_add_multiply_top_tb.sv
